>>> sv/postfix_expression_evaluator_top_macros.svh
// Assertion macros for the postfix evaluator top level.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// ante true at an edge -> cons true at the same edge
`define PFX_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfx assertion failed: same-cycle implication");

// ante true at an edge -> cons true at the next edge
`define PFX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfx assertion failed: next-cycle implication");

// cond holds at every edge out of reset
`define PFX_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("pfx assertion failed: invariant");

`else

`define PFX_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PFX_ASSERT_NEXT(label, clk, rst, ante, cons)
`define PFX_ASSERT_ALWAYS(label, clk, rst, cond)

`endif

`endif

>>> sv/pfx_pkg.sv
// Shared types and constants for the postfix evaluator.
// No dependencies.
package pfx_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W  = 8;
   localparam int LEN_W  = 8;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_MANY_OPS  = 3'd1,
      STATUS_FEW_OPS   = 3'd2,
      STATUS_DIV_ZERO  = 3'd3,
      STATUS_OVERFLOW  = 3'd4
   } pfx_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_POP_R,
      ST_POP_L,
      ST_CALC,
      ST_DIVIDE,
      ST_PUSH,
      ST_FIN_POP,
      ST_EMIT
   } pfx_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic decode;
      logic pop;
      logic latch_right;
      logic latch_left;
      logic calc;
      logic take_quot;
      logic push_res;
      logic emit;
   } pfx_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic take;
      logic oper;
      logic div_op;
      logic last;
      logic right_zero;
      logic div_done;
      logic rsp_busy;
   } pfx_stat_type;

endpackage

>>> sv/postfix_expression_evaluator_top.sv
// Postfix evaluator: one character per request, one result after the last one.
// Steps: load, decode; an operator adds two pops, calc, 32-step divide if / by nonzero, push; last adds pop, emit.
// Throughput: one request at a time; the divider loop and a full result register set the worst case.
// The result register frees the controller once loaded; it stalls only when full.
// Reset (synchronous, active high): stack empty, counts and fault flags cleared.
`include "postfix_expression_evaluator_top_macros.svh"

module postfix_expression_evaluator_top import pfx_pkg::*; #(
   parameter int STACK_DEPTH = 64,
   parameter int MAX_LENGTH  = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_char_code,
   input  logic                     req_last_char,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [2:0]               rsp_status
);

   // command and status bundles between controller and datapath
   pfx_cmd_type  cmd;
   pfx_stat_type stat;

   // major steps of the controller, one per state at most
   logic [4:0]   major_cmd;

   // controller: owns req_ready, walks each request through its steps
   pfx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: stack memory, operand/operator counts, ALU, divider, result register
   pfx_dpath #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_LENGTH  (MAX_LENGTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .cmd           (cmd),
      .stat          (stat)
   );

   assign major_cmd = {cmd.load_req, cmd.decode, cmd.calc, cmd.push_res, cmd.emit};

   // a taken request leaves the controller busy at the next edge
   `PFX_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // a result is only written when the output register can take it
   `PFX_ASSERT_IMPLY(a_emit_room, clock, reset, cmd.emit, !rsp_valid || rsp_ready)
   // the major steps are mutually exclusive
   `PFX_ASSERT_ALWAYS(a_cmd_excl, clock, reset, $onehot0(major_cmd))

endmodule

>>> sv/pfx_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pfx_pkg.
module pfx_div import pfx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   localparam int CW = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;

   logic [DATA_W-1:0] abs_a, abs_b;
   logic [DATA_W:0]   rem_sh, diff;
   logic              ge;

   assign abs_a  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
   assign abs_b  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
   assign rem_sh = {rem_ff, quo_ff[DATA_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign ge     = ~diff[DATA_W];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DATA_W - 1);
         rem_in  = '0;
         quo_in  = abs_a;
         dvs_in  = abs_b;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
         quo_in = {quo_ff[DATA_W-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

>>> sv/pfx_dpath.sv
// Datapath: request latch, value stack memory, counts, ALU, result register.
// Depends on pfx_pkg and pfx_div.
module pfx_dpath import pfx_pkg::*; #(
   parameter int STACK_DEPTH = 64,
   parameter int MAX_LENGTH  = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               req_char_code,
   input  logic                     req_last_char,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic [2:0]               rsp_status,
   input  pfx_cmd_type              cmd,
   output pfx_stat_type             stat
);

   localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam logic [LEN_W-1:0] MAX_LEN_C = LEN_W'(MAX_LENGTH);
   localparam logic [SPW-1:0]   FULL_C    = SPW'(STACK_DEPTH);

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

   logic [7:0]        char_ff, char_in;
   logic              last_ff, last_in;
   logic [SPW-1:0]    sp_ff, sp_in;
   logic [CNT_W-1:0]  opr_ff, opr_in;
   logic [CNT_W-1:0]  opd_ff, opd_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              dfault_ff, dfault_in;
   logic              ofault_ff, ofault_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_empty_ff, rd_empty_in;
   logic [DATA_W-1:0] right_ff, right_in;
   logic [DATA_W-1:0] left_ff, left_in;
   logic [DATA_W-1:0] result_ff, result_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   pfx_status_type    rsp_status_ff, rsp_status_in;

   logic [7:0]          digit_c;
   logic                is_digit, is_oper, is_div, take, full;
   logic                push_en, wr_en, div_start, div_done;
   logic [DATA_W-1:0]   push_val, pop_val, quot;
   logic [2*DATA_W-1:0] prod;
   logic [SPW-1:0]      sp_dec;
   logic [AW-1:0]       wr_addr, rd_addr;
   pfx_status_type      status_c;

   assign digit_c  = char_ff - CHAR_ZERO;
   assign is_digit = (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE);
   assign is_div   = (char_ff == CHAR_SLASH);
   assign is_oper  = (char_ff == CHAR_PLUS) || (char_ff == CHAR_MINUS) ||
                     (char_ff == CHAR_STAR) || is_div;
   assign take     = (len_ff < MAX_LEN_C);
   assign full     = (sp_ff == FULL_C);
   assign sp_dec   = sp_ff - 1'b1;
   assign wr_addr  = sp_ff[AW-1:0];
   assign rd_addr  = sp_dec[AW-1:0];
   assign pop_val  = rd_empty_ff ? '0 : rd_data_ff;
   assign prod     = left_ff * right_ff;

   assign push_en  = (cmd.decode && take && is_digit) || cmd.push_res;
   assign push_val = cmd.push_res ? result_ff : DATA_W'(digit_c[3:0]);
   assign wr_en    = push_en && !full;
   assign div_start = cmd.calc && is_div && (right_ff != '0);

   pfx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (left_ff),
      .divisor  (right_ff),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      if (opr_ff >= opd_ff) begin
         status_c = STATUS_MANY_OPS;
      end else if ({1'b0, opd_ff} != ({1'b0, opr_ff} + 1'b1)) begin
         status_c = STATUS_FEW_OPS;
      end else if (dfault_ff) begin
         status_c = STATUS_DIV_ZERO;
      end else if (ofault_ff) begin
         status_c = STATUS_OVERFLOW;
      end else begin
         status_c = STATUS_OK;
      end
   end

   always_comb begin
      char_in       = char_ff;
      last_in       = last_ff;
      sp_in         = sp_ff;
      opr_in        = opr_ff;
      opd_in        = opd_ff;
      len_in        = len_ff;
      dfault_in     = dfault_ff;
      ofault_in     = ofault_ff;
      rd_empty_in   = rd_empty_ff;
      right_in      = right_ff;
      left_in       = left_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.load_req) begin
         char_in = req_char_code;
         last_in = req_last_char;
      end
      if (cmd.decode && take) begin
         len_in = len_ff + 1'b1;
         if (is_digit && (opd_ff != '1)) begin
            opd_in = opd_ff + 1'b1;
         end
      end
      if (cmd.push_res && (opr_ff != '1)) begin
         opr_in = opr_ff + 1'b1;
      end
      if (push_en) begin
         if (full) begin
            ofault_in = 1'b1;
         end else begin
            sp_in = sp_ff + 1'b1;
         end
      end
      if (cmd.pop) begin
         rd_empty_in = (sp_ff == '0);
         if (sp_ff != '0) begin
            sp_in = sp_dec;
         end
      end
      if (cmd.latch_right) begin
         right_in = pop_val;
      end
      if (cmd.latch_left) begin
         left_in = pop_val;
      end
      if (cmd.calc) begin
         case (char_ff)
            CHAR_PLUS:  result_in = left_ff + right_ff;
            CHAR_MINUS: result_in = left_ff - right_ff;
            CHAR_STAR:  result_in = prod[DATA_W-1:0];
            default: begin
               // divide by zero yields 0 and flags the fault
               result_in = '0;
               if (right_ff == '0) begin
                  dfault_in = 1'b1;
               end
            end
         endcase
      end
      if (cmd.take_quot) begin
         result_in = quot;
      end
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = pop_val;
         rsp_status_in = status_c;
         sp_in         = '0;
         opr_in        = '0;
         opd_in        = '0;
         len_in        = '0;
         dfault_in     = 1'b0;
         ofault_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         opr_ff       <= '0;
         opd_ff       <= '0;
         len_ff       <= '0;
         dfault_ff    <= 1'b0;
         ofault_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         opr_ff       <= opr_in;
         opd_ff       <= opd_in;
         len_ff       <= len_in;
         dfault_ff    <= dfault_in;
         ofault_ff    <= ofault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      char_ff       <= char_in;
      last_ff       <= last_in;
      rd_empty_ff   <= rd_empty_in;
      right_ff      <= right_in;
      left_ff       <= left_in;
      result_ff     <= result_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // stack memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= push_val;
      end
      if (cmd.pop) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign stat.take       = take;
   assign stat.oper       = is_oper;
   assign stat.div_op     = is_div;
   assign stat.last       = last_ff;
   assign stat.right_zero = (right_ff == '0);
   assign stat.div_done   = div_done;
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

>>> sv/pfx_ctrl.sv
// Controller state machine: sequences decode, pops, ALU/divide, push and emit.
// Depends on pfx_pkg.
module pfx_ctrl import pfx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  pfx_stat_type stat,
   output pfx_cmd_type  cmd
);

   pfx_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            if (stat.take && stat.oper) begin
               cmd.pop  = 1'b1;
               state_in = ST_POP_R;
            end else begin
               state_in = stat.last ? ST_FIN_POP : ST_IDLE;
            end
         end
         ST_POP_R: begin
            cmd.latch_right = 1'b1;
            cmd.pop         = 1'b1;
            state_in        = ST_POP_L;
         end
         ST_POP_L: begin
            cmd.latch_left = 1'b1;
            state_in       = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = (stat.div_op && !stat.right_zero) ? ST_DIVIDE : ST_PUSH;
         end
         ST_DIVIDE: begin
            if (stat.div_done) begin
               cmd.take_quot = 1'b1;
               state_in      = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push_res = 1'b1;
            state_in     = stat.last ? ST_FIN_POP : ST_IDLE;
         end
         ST_FIN_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!stat.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> tb/sv/postfix_expression_evaluator_check.sv
// Passive checker for the postfix evaluator: rebuilds each expression from the
// accepted requests, predicts value and status, and compares every result.
// Depends on pfx_pkg.
module postfix_expression_evaluator_check import pfx_pkg::*; #(
   parameter int STACK_DEPTH = 64,
   parameter int MAX_LENGTH  = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [7:0]               req_char_code,
   input  logic                     req_last_char,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic signed [DATA_W-1:0] rsp_value,
   input  logic [2:0]               rsp_status,
   output int                       fail_count,
   output int                       pending
);

   localparam int COUNT_MAX = 255;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      pfx_status_type    status;
   } rpn_answer_type;

   logic [DATA_W-1:0] operand_stack [STACK_DEPTH];
   int                stack_fill;
   int                ops_seen;
   int                nums_seen;
   int                chars_seen;
   bit                zero_divisor_seen;
   bit                stack_spilled;
   rpn_answer_type    answer_queue [$];

   function automatic void clear_expression();
      stack_fill        = 0;
      ops_seen          = 0;
      nums_seen         = 0;
      chars_seen        = 0;
      zero_divisor_seen = 1'b0;
      stack_spilled     = 1'b0;
   endfunction

   // full stack: value dropped, fault remembered
   function automatic void push_operand(logic [DATA_W-1:0] v);
      if (stack_fill < STACK_DEPTH) begin
         operand_stack[stack_fill] = v;
         stack_fill++;
      end else begin
         stack_spilled = 1'b1;
      end
   endfunction

   // empty stack reads as zero
   function automatic logic [DATA_W-1:0] pop_operand();
      if (stack_fill == 0)
         return '0;
      stack_fill--;
      return operand_stack[stack_fill];
   endfunction

   function automatic logic [DATA_W-1:0] apply_operator(logic [7:0] op,
                                                        logic [DATA_W-1:0] lhs,
                                                        logic [DATA_W-1:0] rhs);
      longint quotient;
      case (op)
         CHAR_PLUS:  return lhs + rhs;
         CHAR_MINUS: return lhs - rhs;
         CHAR_STAR:  return lhs * rhs;
         default: begin
            if (rhs == '0) begin
               zero_divisor_seen = 1'b1;
               return '0;
            end
            // 64-bit divide so most-negative / -1 wraps instead of trapping
            quotient = longint'($signed(lhs)) / longint'($signed(rhs));
            return quotient[DATA_W-1:0];
         end
      endcase
   endfunction

   function automatic void eval_char(logic [7:0] c);
      logic [DATA_W-1:0] digit;
      logic [DATA_W-1:0] rhs;
      logic [DATA_W-1:0] lhs;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         digit = DATA_W'(c - CHAR_ZERO);
         push_operand(digit);
         if (nums_seen < COUNT_MAX)
            nums_seen++;
      end else if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR ||
                   c == CHAR_SLASH) begin
         rhs = pop_operand();
         lhs = pop_operand();
         push_operand(apply_operator(c, lhs, rhs));
         if (ops_seen < COUNT_MAX)
            ops_seen++;
      end
   endfunction

   function automatic rpn_answer_type close_expression();
      rpn_answer_type ans;
      ans.value = pop_operand();
      if (ops_seen >= nums_seen)
         ans.status = STATUS_MANY_OPS;
      else if (nums_seen != ops_seen + 1)
         ans.status = STATUS_FEW_OPS;
      else if (zero_divisor_seen)
         ans.status = STATUS_DIV_ZERO;
      else if (stack_spilled)
         ans.status = STATUS_OVERFLOW;
      else
         ans.status = STATUS_OK;
      clear_expression();
      return ans;
   endfunction

   // result side first: a result never belongs to a request taken on the same edge
   always @(posedge clock) begin : watch
      rpn_answer_type want;
      if (reset) begin
         clear_expression();
         answer_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answer_queue.size() == 0) begin
               $error("unexpected result: value %0d status %0d", rsp_value, rsp_status);
               fail_count++;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, got %0d", $signed(want.value), rsp_value);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (chars_seen < MAX_LENGTH) begin
               chars_seen++;
               eval_char(req_char_code);
            end
            if (req_last_char)
               answer_queue.push_back(close_expression());
         end
      end
      pending = answer_queue.size();
   end

endmodule

>>> tb/sv/postfix_expression_evaluator_top_test.sv
// Testbench top for the postfix evaluator: clock, reset, request stimulus,
// result-side back-pressure, watchdog and verdict. Depends on pfx_pkg, the
// evaluator RTL and postfix_expression_evaluator_check.
module postfix_expression_evaluator_top_test;
   import pfx_pkg::*;

   localparam int STACK_DEPTH  = 64;
   localparam int MAX_LENGTH   = 128;
   localparam int TARGET_ITEMS = 1950;
   // last stretch of the run goes without any idling
   localparam int TAIL_START   = TARGET_ITEMS * 17 / 20;
   // worst quiet stretch: a divide plus an idle gap plus a result stall; take it many times
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 60;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TOP   = 8'hFF;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_char_code = '0;
   logic                     req_last_char = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_value;
   logic [2:0]               rsp_status;

   int fail_count;
   int pending;

   // characters of the expression being built; last one carries the marker
   logic [7:0] expr_text [$];
   int         items_sent;
   bit         gaps_on;
   bit         rsp_stalls_on;
   bit         quiet_tail;
   int         stall_left;
   int         quiet_cycles;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   postfix_expression_evaluator_top #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_LENGTH  (MAX_LENGTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status)
   );

   postfix_expression_evaluator_check #(
      .STACK_DEPTH (STACK_DEPTH),
      .MAX_LENGTH  (MAX_LENGTH)
   ) result_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   // ---------------------------------------------------------------------
   // Character pickers
   // ---------------------------------------------------------------------
   function automatic bit is_significant(logic [7:0] c);
      return (c >= CHAR_ZERO && c <= CHAR_NINE) || c == CHAR_PLUS ||
             c == CHAR_MINUS || c == CHAR_STAR || c == CHAR_SLASH;
   endfunction

   function automatic logic [7:0] digit_char(int n);
      return CHAR_ZERO + n[7:0];
   endfunction

   function automatic logic [7:0] any_digit();
      return digit_char($urandom_range(0, 9));
   endfunction

   // products = mostly multiplies, to push values past 32 bits and wrap
   function automatic logic [7:0] any_operator(bit products);
      if (products && $urandom_range(0, 3) != 0)
         return CHAR_STAR;
      case ($urandom_range(0, 3))
         0:       return CHAR_PLUS;
         1:       return CHAR_MINUS;
         2:       return CHAR_STAR;
         default: return CHAR_SLASH;
      endcase
   endfunction

   // any byte the evaluator skips over
   function automatic logic [7:0] filler_char();
      logic [7:0] c;
      do
         c = 8'($urandom_range(0, 255));
      while (is_significant(c));
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Expression builders
   // ---------------------------------------------------------------------
   // balanced postfix: operands = operators + 1, random layout, some filler
   function automatic void build_wellformed(int operands, bit products);
      int held = 0;
      int left = operands;
      while (left > 0 || held > 1) begin
         if ($urandom_range(0, 9) == 0)
            expr_text.push_back(filler_char());
         if (left > 0 && (held < 2 || $urandom_range(0, 1) == 0)) begin
            expr_text.push_back(any_digit());
            left--;
            held++;
         end else begin
            expr_text.push_back(any_operator(products));
            held--;
         end
      end
      // sometimes the marker rides on a skipped character
      if ($urandom_range(0, 7) == 0)
         expr_text.push_back(filler_char());
   endfunction

   // unbalanced mix of digits, operators and arbitrary bytes
   function automatic void build_broken(int n);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0, 1:    expr_text.push_back(any_digit());
            2:       expr_text.push_back(any_operator(1'b0));
            default: expr_text.push_back(8'($urandom_range(0, 255)));
         endcase
      end
   endfunction

   // fill the stack to near the brim and sometimes past it
   function automatic void build_deep();
      int fill = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
      repeat (fill) expr_text.push_back(any_digit());
      repeat ($urandom_range(0, 6)) expr_text.push_back(any_operator(1'b0));
   endfunction

   // 8^10 * 2 wraps to the most negative value, then divide it by 0 - 1
   function automatic void build_wrap_division();
      expr_text.push_back(digit_char(8));
      repeat (9) begin
         expr_text.push_back(digit_char(8));
         expr_text.push_back(CHAR_STAR);
      end
      expr_text.push_back(digit_char(2));
      expr_text.push_back(CHAR_STAR);
      expr_text.push_back(digit_char(0));
      expr_text.push_back(digit_char(1));
      expr_text.push_back(CHAR_MINUS);
      expr_text.push_back(CHAR_SLASH);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: payload changes at the falling edge, valid holds until
   // the request is taken. Called and returns at a falling edge.
   // ---------------------------------------------------------------------
   task automatic send_char(input logic [7:0] c, input logic is_last);
      if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_last_char <= is_last;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
      items_sent++;
      quiet_tail = items_sent >= TAIL_START;
   endtask

   // each expression picks its own idling mood, so some run back to back
   task automatic send_expression();
      logic [7:0] c;
      gaps_on       = !quiet_tail && ($urandom_range(0, 3) != 0);
      rsp_stalls_on = !quiet_tail && ($urandom_range(0, 3) != 0);
      while (expr_text.size() > 0) begin
         c = expr_text.pop_front();
         send_char(c, expr_text.size() == 0);
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: ready drops in random bursts of stalled cycles
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_stalls_on && !quiet_tail && $urandom_range(0, 5) == 0)
            stall_left <= $urandom_range(1, 15);
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: cycles with no request and no result taken
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and verdict
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int shape;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed ---
      // lone operands, smallest and largest digit
      expr_text.push_back(digit_char(0));
      send_expression();
      expr_text.push_back(digit_char(9));
      send_expression();
      // operand order: 3 - 9 gives -6
      expr_text.push_back(digit_char(3));
      expr_text.push_back(digit_char(9));
      expr_text.push_back(CHAR_MINUS);
      send_expression();
      expr_text.push_back(digit_char(7));
      expr_text.push_back(digit_char(8));
      expr_text.push_back(CHAR_STAR);
      send_expression();
      // -7 / 3 truncates toward zero to -2
      expr_text.push_back(digit_char(0));
      expr_text.push_back(digit_char(7));
      expr_text.push_back(CHAR_MINUS);
      expr_text.push_back(digit_char(3));
      expr_text.push_back(CHAR_SLASH);
      send_expression();
      // divide by zero
      expr_text.push_back(digit_char(5));
      expr_text.push_back(digit_char(0));
      expr_text.push_back(CHAR_SLASH);
      send_expression();
      // operator on an empty stack pops zeros
      expr_text.push_back(CHAR_PLUS);
      send_expression();
      // operands left over
      expr_text.push_back(digit_char(1));
      expr_text.push_back(digit_char(2));
      send_expression();
      // nothing but skipped characters
      expr_text.push_back(CHAR_SPACE);
      send_expression();
      expr_text.push_back(CHAR_TOP);
      send_expression();
      // marker on a skipped NUL after a sum
      expr_text.push_back(digit_char(6));
      expr_text.push_back(digit_char(2));
      expr_text.push_back(CHAR_PLUS);
      expr_text.push_back(CHAR_NUL);
      send_expression();

      // --- random: open with the long corner shapes once each ---
      build_wrap_division();
      send_expression();
      build_deep();
      send_expression();
      build_broken($urandom_range(MAX_LENGTH + 1, MAX_LENGTH + 8));
      send_expression();

      while (items_sent < TARGET_ITEMS) begin
         shape = $urandom_range(0, 199);
         if (shape < 110) begin
            build_wellformed($urandom_range(1, 8), 1'b0);
         end else if (shape < 130) begin
            build_wellformed($urandom_range(9, 30), 1'b1);
         end else if (shape < 152) begin
            build_broken($urandom_range(1, 12));
         end else if (shape < 164) begin
            build_broken(0);
            repeat ($urandom_range(1, 6)) expr_text.push_back(8'($urandom_range(0, 255)));
         end else if (shape < 180) begin
            // one operand or one operator too many
            build_wellformed($urandom_range(1, 6), 1'b0);
            if ($urandom_range(0, 1) == 0)
               expr_text.push_back(any_digit());
            else
               expr_text.push_back(any_operator(1'b0));
         end else if (shape < 183) begin
            build_deep();
         end else if (shape < 186) begin
            // past the length cap: tail is skipped but the marker still counts
            build_broken($urandom_range(MAX_LENGTH + 1, MAX_LENGTH + 8));
         end else if (shape < 192) begin
            build_wrap_division();
         end else begin
            // empty stack cases
            case ($urandom_range(0, 2))
               0: expr_text.push_back(filler_char());
               1: expr_text.push_back(any_operator(1'b0));
               default: begin
                  expr_text.push_back(any_operator(1'b0));
                  expr_text.push_back(any_operator(1'b0));
               end
            endcase
         end
         send_expression();
      end
      req_valid <= 1'b0;

      // drain, then give the block time to show anything unexpected
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
